@@ rtl/core/sensor_register_frame_responder_top_macros.svh @@
// Assertion helpers for the frame responder.
`ifndef SENSOR_REGISTER_FRAME_RESPONDER_TOP_MACROS_SVH
`define SENSOR_REGISTER_FRAME_RESPONDER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define SRFR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked out of reset.
`define SRFR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SRFR_ASSERT_IMP(label, ante, cons, msg)
`define SRFR_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

@@ rtl/core/srfr_pkg.sv @@
package srfr_pkg;

    localparam int NUM_REGS = 10;
    localparam int SEQ_BITS = 8;
    localparam int ADDR_W   = $clog2(NUM_REGS);

    localparam logic [ADDR_W-1:0] IDX_STATUS  = ADDR_W'(2);
    localparam logic [ADDR_W-1:0] IDX_CTRL    = ADDR_W'(3);
    localparam logic [ADDR_W-1:0] IDX_RATE    = ADDR_W'(4);
    localparam logic [ADDR_W-1:0] IDX_SCRATCH = ADDR_W'(9);

    typedef enum logic [2:0] {
        CMD_PING,
        CMD_RESET,
        CMD_STATUS,
        CMD_READ,
        CMD_WRITE,
        CMD_STREAM_START,
        CMD_STREAM_STOP,
        CMD_UNKNOWN
    } t_cmd;

    localparam logic [1:0] KIND_ACK  = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_NACK = 2'd2;
    localparam logic [1:0] KIND_RSVD = 2'd3;

    localparam logic [7:0] ERR_RANGE   = 8'd0;
    localparam logic [7:0] ERR_UNKNOWN = 8'd1;

    localparam logic [1:0] CFG_RESET_CODE     = 2'd0;
    localparam logic [1:0] CFG_STREAM_ON_CODE = 2'd1;
    localparam logic [1:0] CFG_STREAMING_MASK = 2'd2;

    typedef struct packed {
        logic [15:0] ctrl_reset_code;
        logic [15:0] ctrl_stream_on_code;
        logic [15:0] streaming_mask;
    } t_cfg;

    typedef struct packed {
        logic [7:0] seq;
        logic [1:0] resp_kind;
        logic [1:0] resp_length;
        logic [7:0] payload_0;
        logic [7:0] payload_1;
        logic [7:0] payload_2;
    } t_resp;

    // Power-up contents of the register file.
    function automatic logic [15:0] f_reg_default(input logic [ADDR_W-1:0] idx);
        logic [15:0] v;
        v = 16'h0000;
        case (idx)
            ADDR_W'(0): v = 16'hCAFE;
            ADDR_W'(1): v = 16'h0100;
            ADDR_W'(2): v = 16'h0001;
            ADDR_W'(4): v = 16'd10;
            ADDR_W'(5): v = 16'd250;
            ADDR_W'(8): v = 16'd1000;
            default:    v = 16'h0000;
        endcase
        return v;
    endfunction

    // Control, sample rate and scratch accept host writes.
    function automatic logic f_writable(input logic [ADDR_W-1:0] idx);
        return (idx == IDX_CTRL) || (idx == IDX_RATE) || (idx == IDX_SCRATCH);
    endfunction

endpackage

@@ rtl/core/srfr_regs.sv @@
module srfr_regs
    import srfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [2:0]  i_command,
    input  logic [7:0]  i_reg_addr,
    input  logic [15:0] i_write_value,
    input  t_cfg        i_cfg,
    output t_resp       o_resp
);

    logic [15:0]         r_store [NUM_REGS];
    logic [15:0]         n_store [NUM_REGS];
    logic [SEQ_BITS-1:0] r_seq;
    logic [SEQ_BITS-1:0] n_seq;

    logic              addr_ok;
    logic              wr_ok;
    logic [ADDR_W-1:0] idx;
    logic [15:0]       rd_val;
    t_cmd              cmd;

    assign cmd     = t_cmd'(i_command);
    assign addr_ok = (i_reg_addr < 8'(NUM_REGS));
    assign idx     = i_reg_addr[ADDR_W-1:0];
    assign wr_ok   = addr_ok && f_writable(idx);

    always_comb begin
        rd_val = 16'h0000;
        for (int i = 0; i < NUM_REGS; i++) begin
            if (idx == ADDR_W'(i)) begin
                rd_val = r_store[i];
            end
        end
    end

    always_comb begin
        n_store = r_store;
        n_seq   = SEQ_BITS'(r_seq + 1'b1);

        o_resp             = '0;
        o_resp.seq         = r_seq[7:0];
        o_resp.resp_kind   = KIND_ACK;

        unique case (cmd)
            CMD_PING: begin
            end
            CMD_RESET: begin
                for (int i = 0; i < NUM_REGS; i++) begin
                    n_store[i] = f_reg_default(ADDR_W'(i));
                end
                n_seq = '0;
            end
            CMD_STATUS: begin
                o_resp.resp_length = 2'd2;
                o_resp.payload_0   = r_store[IDX_STATUS][15:8];
                o_resp.payload_1   = r_store[IDX_STATUS][7:0];
            end
            CMD_READ: begin
                if (addr_ok) begin
                    o_resp.resp_kind   = KIND_DATA;
                    o_resp.resp_length = 2'd3;
                    o_resp.payload_0   = i_reg_addr;
                    o_resp.payload_1   = rd_val[15:8];
                    o_resp.payload_2   = rd_val[7:0];
                end else begin
                    o_resp.resp_kind   = KIND_NACK;
                    o_resp.resp_length = 2'd1;
                    o_resp.payload_0   = ERR_RANGE;
                end
            end
            CMD_WRITE: begin
                if (wr_ok) begin
                    for (int i = 0; i < NUM_REGS; i++) begin
                        if (idx == ADDR_W'(i)) begin
                            n_store[i] = i_write_value;
                        end
                    end
                    if (idx == IDX_CTRL) begin
                        if (i_write_value == i_cfg.ctrl_reset_code) begin
                            for (int i = 0; i < NUM_REGS; i++) begin
                                n_store[i] = f_reg_default(ADDR_W'(i));
                            end
                            n_seq = '0;
                        end else if (i_write_value == i_cfg.ctrl_stream_on_code) begin
                            n_store[IDX_STATUS] = r_store[IDX_STATUS] | i_cfg.streaming_mask;
                        end
                    end
                end else begin
                    o_resp.resp_kind   = KIND_NACK;
                    o_resp.resp_length = 2'd1;
                    o_resp.payload_0   = ERR_RANGE;
                end
            end
            CMD_STREAM_START: begin
                n_store[IDX_STATUS] = r_store[IDX_STATUS] | i_cfg.streaming_mask;
            end
            CMD_STREAM_STOP: begin
                n_store[IDX_STATUS] = r_store[IDX_STATUS] & ~i_cfg.streaming_mask;
            end
            default: begin
                o_resp.resp_kind   = KIND_NACK;
                o_resp.resp_length = 2'd1;
                o_resp.payload_0   = ERR_UNKNOWN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_store[i] <= f_reg_default(ADDR_W'(i));
            end
            r_seq <= '0;
        end else if (i_accept) begin
            r_store <= n_store;
            r_seq   <= n_seq;
        end
    end

endmodule

@@ rtl/core/srfr_skid.sv @@
module srfr_skid
    import srfr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_resp i_resp,
    input  logic  i_stall,
    output logic  o_valid,
    output logic  o_full,
    output t_resp o_resp
);

    logic  r_main_valid;
    logic  r_skid_valid;
    t_resp r_main;
    t_resp r_skid;
    logic  pop;

    assign pop     = r_main_valid && !i_stall;
    assign o_valid = r_main_valid;
    assign o_full  = r_skid_valid;
    assign o_resp  = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (pop) begin
                if (r_skid_valid) begin
                    r_skid_valid <= i_push;
                end else begin
                    r_main_valid <= i_push;
                end
            end else if (!r_main_valid) begin
                r_main_valid <= i_push;
            end else if (i_push) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_skid_valid) begin
                r_main <= r_skid;
                r_skid <= i_resp;
            end else begin
                r_main <= i_resp;
            end
        end else if (!r_main_valid) begin
            r_main <= i_resp;
        end else if (i_push) begin
            r_skid <= i_resp;
        end
    end

endmodule

@@ rtl/core/sensor_register_frame_responder_top.sv @@
// The response to an accepted request beat is registered in the output buffer.
// Throughput: one request per cycle while the output buffer has a free slot; the register
// file and sequence counter update in the accepting cycle, so a request sees every earlier request's effect.
// A two-entry output buffer keeps requests flowing while one response waits.
// Reset (synchronous, active low): register file to defaults, sequence to zero,
// config codes to 1 / 2 / 2, output buffer empty.
`include "sensor_register_frame_responder_top_macros.svh"

module sensor_register_frame_responder_top
    import srfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_command,
    input  logic [7:0]  i_reg_addr,
    input  logic [15:0] i_write_value,

    // response channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_seq,
    output logic [1:0]  o_resp_kind,
    output logic [1:0]  o_resp_length,
    output logic [7:0]  o_payload_0,
    output logic [7:0]  o_payload_1,
    output logic [7:0]  o_payload_2,

    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg  r_cfg;
    t_resp resp;
    t_resp out_resp;
    logic  accept;
    logic  buf_full;

    // Take a request beat whenever the output buffer has a free slot.
    assign o_in_stall = buf_full;
    assign accept     = i_in_valid && !buf_full;

    // Config is always writable.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ctrl_reset_code     <= 16'd1;
            r_cfg.ctrl_stream_on_code <= 16'd2;
            r_cfg.streaming_mask      <= 16'd2;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_RESET_CODE:     r_cfg.ctrl_reset_code     <= i_cfg_data;
                CFG_STREAM_ON_CODE: r_cfg.ctrl_stream_on_code <= i_cfg_data;
                CFG_STREAMING_MASK: r_cfg.streaming_mask      <= i_cfg_data;
                default: begin
                    // drop writes past the register list
                end
            endcase
        end
    end

    // Decode the request, update the register file, build the response.
    srfr_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_command     (i_command),
        .i_reg_addr    (i_reg_addr),
        .i_write_value (i_write_value),
        .i_cfg         (r_cfg),
        .o_resp        (resp)
    );

    // Hold responses until the downstream side takes them.
    srfr_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_resp  (resp),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_full  (buf_full),
        .o_resp  (out_resp)
    );

    assign o_seq         = out_resp.seq;
    assign o_resp_kind   = out_resp.resp_kind;
    assign o_resp_length = out_resp.resp_length;
    assign o_payload_0   = out_resp.payload_0;
    assign o_payload_1   = out_resp.payload_1;
    assign o_payload_2   = out_resp.payload_2;

    // A full buffer always has a response on the output.
    `SRFR_ASSERT_IMP(a_full_has_out, o_in_stall, o_out_valid, "stall without pending response")
    // After an accepted beat, the output holds a valid response on the next cycle.
    `SRFR_ASSERT_NXT(a_accept_gives_out, i_in_valid && !o_in_stall, o_out_valid, "response lost")
    // The reserved response kind is never produced.
    `SRFR_ASSERT_IMP(a_kind_legal, o_out_valid, o_resp_kind != KIND_RSVD, "reserved response kind")
    // A nack carries exactly its error code.
    `SRFR_ASSERT_IMP(a_nack_len, o_out_valid && o_resp_kind == KIND_NACK, o_resp_length == 2'd1, "nack length wrong")

endmodule
